// ----- rtl/core/rbe_pkg.sv -----
// package for the rect blit engine: action codes, register indexes, helpers
// no dependencies
`default_nettype none
package rbe_pkg;
  localparam int unsigned CoordW = 9;
  localparam int unsigned PixW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [15:0] Mask8 = 16'h00FF;

  typedef enum logic [1:0] {
    ACT_WR_SRC = 2'd0,
    ACT_WR_DST = 2'd1,
    ACT_RD_DST = 2'd2,
    ACT_BLIT   = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SRC_W   = 3'd0,
    REG_SRC_H   = 3'd1,
    REG_DST_W   = 3'd2,
    REG_DST_H   = 3'd3,
    REG_PIX16   = 3'd4,
    REG_KEY_LO  = 3'd5,
    REG_KEY_HI  = 3'd6,
    REG_UNUSED  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [PixW-1:0]   pixel;
    logic [CoordW-1:0] src_left;
    logic [CoordW-1:0] src_top;
    logic [CoordW-1:0] src_right;
    logic [CoordW-1:0] src_bottom;
    logic [CoordW-1:0] dst_right;
    logic [CoordW-1:0] dst_bottom;
    logic              fill_enable;
    logic              key_enable;
  } req_t;

  typedef struct packed {
    logic [PixW-1:0]   read_data;
    logic              stretched;
    logic [CoordW-1:0] copy_width;
    logic [CoordW-1:0] copy_height;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [PixW-1:0]    data;
  } cfg_t;

  function automatic logic [CoordW-1:0] min9(input logic [CoordW-1:0] a,
                                             input logic [CoordW-1:0] b);
    return (a < b) ? a : b;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/rbe_if.sv -----
// valid/ready channel interface carrying one payload of type T
// no dependencies; the payload type T is a parameter
`default_nettype none
interface rbe_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rbe_div.sv -----
// restoring divider for the 9.16 stretch ratio, one quotient bit per cycle
// depends on rbe_pkg
`default_nettype none
module rbe_div
  import rbe_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [CoordW-1:0] num_i,
  input  wire logic [CoordW-1:0] den_i,
  output logic                   done_o,
  output logic [24:0]            quot_o
);
  localparam int unsigned NumW = CoordW + 16;
  logic [NumW-1:0]   num_q, num_d;
  logic [CoordW:0]   rem_q, rem_d;
  logic [CoordW-1:0] den_q;
  logic [4:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              load;
  logic [CoordW+1:0] trial;

  // a start request is ignored while a division is running
  assign load = start_i && !busy_q;

  always_comb begin
    trial = {rem_q, num_q[NumW-1]} - {2'b00, den_q};
    num_d = num_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (load) begin
      num_d = {num_i, 16'h0000};
      rem_d = '0;
      cnt_d = 5'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[CoordW+1]) begin
        rem_d = trial[CoordW:0];
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[CoordW-1:0], num_q[NumW-1]};
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (load) den_q <= den_i;
  end

  // quotient is complete in the cycle done is high
  assign done_o = done_q;
  assign quot_o = num_q;
endmodule
`default_nettype wire

// ----- rtl/core/rect_blit_engine_top.sv -----
// top level of the rect blit engine: surfaces, sequencer and register file
// depends on rbe_pkg, rbe_if and rbe_div
//
// A pixel write passes through the clip and result states and a destination
// read through the clip, read and result states; the input stays blocked until
// the result is taken, so a new request waits for the previous result. A blit
// passes through the clip state, then the fill state, which writes the fill
// pixels when fill is enabled, then a decision, then per transferred pixel a
// source read and a destination write, and then the result; a stretched blit
// first runs two serial divisions for the scale ratios, and a keyed stretched
// blit transfers no pixels. The two surface memories each have one write port
// and one registered read port. Memories are not cleared: reading unwritten
// pixels yields undefined data.
`default_nettype none
module rect_blit_engine_top
  import rbe_pkg::*;
#(
  parameter int unsigned MAX_SURFACE_WIDTH = 256,
  parameter int unsigned MAX_SURFACE_HEIGHT = 256
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  rbe_if.sink      cfg_i,
  rbe_if.sink      in_i,
  rbe_if.source    out_o
);
  localparam int unsigned Depth = MAX_SURFACE_WIDTH * MAX_SURFACE_HEIGHT;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned AW = AddrW + 2;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CLIP  = 9'b000000010,
    ST_FILL  = 9'b000000100,
    ST_DIVX  = 9'b000001000,
    ST_DIVY  = 9'b000010000,
    ST_RDSRC = 9'b000100000,
    ST_WRDST = 9'b001000000,
    ST_RDDST = 9'b010000000,
    ST_RESP  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [CoordW-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic pix16_q;
  logic [PixW-1:0] key_lo_q, key_hi_q;

  logic [PixW-1:0] src_mem [Depth];
  logic [PixW-1:0] dst_mem [Depth];
  logic [PixW-1:0] src_rd_q, dst_rd_q;

  req_t req_q;
  rsp_t rsp_q;
  logic out_valid_q;

  // clipped geometry
  logic [CoordW-1:0] sl_q, st_q, dl_q, dt_q, ws_q, hs_q, wd_q, hd_q;
  logic [CoordW-1:0] x_q, y_q, xw_q, yh_q;
  logic stretch_q;
  logic [24:0] xr_q, yr_q;
  logic [33:0] sx_acc_q, sy_acc_q;

  // register file
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 9'd256;
      src_h_q <= 9'd256;
      dst_w_q <= 9'd256;
      dst_h_q <= 9'd256;
      pix16_q <= 1'b0;
      key_lo_q <= '0;
      key_hi_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.data.index))
        REG_SRC_W:  src_w_q <= cfg_i.data.data[CoordW-1:0];
        REG_SRC_H:  src_h_q <= cfg_i.data.data[CoordW-1:0];
        REG_DST_W:  dst_w_q <= cfg_i.data.data[CoordW-1:0];
        REG_DST_H:  dst_h_q <= cfg_i.data.data[CoordW-1:0];
        REG_PIX16:  pix16_q <= cfg_i.data.data[0];
        REG_KEY_LO: key_lo_q <= cfg_i.data.data;
        REG_KEY_HI: key_hi_q <= cfg_i.data.data;
        default: ;
      endcase
    end
  end

  function automatic logic [CoordW-1:0] sat(input logic [CoordW-1:0] v, input int unsigned m);
    logic [CoordW-1:0] mm;
    mm = (m > 256) ? 9'd256 : CoordW'(m);
    return (v > mm) ? mm : v;
  endfunction

  logic [CoordW-1:0] sw, sh, dw, dh;
  assign sw = sat(src_w_q, MAX_SURFACE_WIDTH);
  assign sh = sat(src_h_q, MAX_SURFACE_HEIGHT);
  assign dw = sat(dst_w_q, MAX_SURFACE_WIDTH);
  assign dh = sat(dst_h_q, MAX_SURFACE_HEIGHT);

  function automatic logic [PixW-1:0] pmask(input logic [PixW-1:0] v, input logic p16);
    return p16 ? v : (v & Mask8);
  endfunction

  // y * pitch + x; width keeps carry
  function automatic logic [AW-1:0] lin(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                                        input logic [CoordW-1:0] p);
    logic [2*CoordW:0] s;
    s = (2*CoordW+1)'(y) * (2*CoordW+1)'(p) + (2*CoordW+1)'(x);
    return AW'(s);
  endfunction

  // division
  logic div_start, div_done;
  logic [CoordW-1:0] div_num, div_den;
  logic [24:0] div_quot;
  rbe_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quot)
  );

  // scaled source coordinates
  logic [CoordW-1:0] sx, sy;
  always_comb begin
    sx = (sx_acc_q[33:16] > {9'd0, ws_q - 9'd1}) ? ws_q - 9'd1 : sx_acc_q[24:16];
    sy = (sy_acc_q[33:16] > {9'd0, hs_q - 9'd1}) ? hs_q - 9'd1 : sy_acc_q[24:16];
  end

  logic [CoordW-1:0] src_x, src_y;
  assign src_x = stretch_q ? sl_q + sx : sl_q + x_q;
  assign src_y = stretch_q ? st_q + sy : st_q + y_q;

  logic [AW-1:0] src_addr, dst_addr, acc_addr;
  assign src_addr = lin(src_x, src_y, sw);
  assign dst_addr = lin(dl_q + x_q, dt_q + y_q, dw);
  assign acc_addr = lin(req_q.pos_x, req_q.pos_y, (req_q.action == ACT_WR_SRC) ? sw : dw);

  logic [PixW-1:0] cpix;
  logic keep;
  assign cpix = pmask(src_rd_q, pix16_q);
  assign keep = !req_q.key_enable || (cpix < key_lo_q) || (cpix > key_hi_q);

  logic src_we, dst_we, src_re, dst_re;
  logic [AW-1:0] src_wa, dst_wa;
  logic [PixW-1:0] dst_wd;
  logic last_x, last_y;
  assign last_x = (x_q == xw_q - 9'd1);
  assign last_y = (y_q == yh_q - 9'd1);

  logic in_fire;
  assign in_i.ready = (state_q == ST_IDLE) && !out_valid_q;
  assign in_fire = in_i.valid && in_i.ready;

  logic set_rsp;
  rsp_t rsp_d;
  logic acc_ok;
  assign acc_ok = (req_q.action == ACT_WR_SRC) ? (req_q.pos_x < sw && req_q.pos_y < sh)
                                               : (req_q.pos_x < dw && req_q.pos_y < dh);

  logic [CoordW-1:0] c_sr, c_sl, c_sb, c_st, c_dr, c_dl, c_db, c_dt;
  logic [CoordW:0] usw, ush, udw, udh;
  always_comb begin
    c_sr = min9(req_q.src_right, sw);
    c_sl = min9(req_q.src_left, c_sr);
    c_sb = min9(req_q.src_bottom, sh);
    c_st = min9(req_q.src_top, c_sb);
    c_dr = min9(req_q.dst_right, dw);
    c_dl = min9(req_q.pos_x, c_dr);
    c_db = min9(req_q.dst_bottom, dh);
    c_dt = min9(req_q.pos_y, c_db);
    usw = {1'b0, req_q.src_right} - {1'b0, req_q.src_left};
    ush = {1'b0, req_q.src_bottom} - {1'b0, req_q.src_top};
    udw = {1'b0, req_q.dst_right} - {1'b0, req_q.pos_x};
    udh = {1'b0, req_q.dst_bottom} - {1'b0, req_q.pos_y};
  end

  logic xfer_ok;
  assign xfer_ok = ws_q != 0 && hs_q != 0 && wd_q != 0 && hd_q != 0;

  always_comb begin
    state_d = state_q;
    src_we = 1'b0; dst_we = 1'b0; src_re = 1'b0; dst_re = 1'b0;
    src_wa = acc_addr; dst_wa = acc_addr;
    dst_wd = pmask(req_q.pixel, pix16_q);
    div_start = 1'b0;
    div_num = ws_q; div_den = wd_q;
    set_rsp = 1'b0;
    rsp_d = rsp_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_CLIP;
      end
      ST_CLIP: begin
        rsp_d = '0;
        set_rsp = 1'b1;
        unique case (action_e'(req_q.action))
          ACT_WR_SRC: begin
            src_we = acc_ok;
            state_d = ST_RESP;
          end
          ACT_WR_DST: begin
            dst_we = acc_ok;
            state_d = ST_RESP;
          end
          ACT_RD_DST: begin
            dst_re = acc_ok;
            state_d = acc_ok ? ST_RDDST : ST_RESP;
          end
          ACT_BLIT: begin
            rsp_d.stretched = (usw != udw) || (ush != udh);
            state_d = ST_FILL;
          end
          default: ;
        endcase
      end
      ST_FILL: begin
        // first fill cycle also decides; geometry registered in clip
        if (req_q.fill_enable && wd_q != 0 && hd_q != 0) begin
          dst_we = 1'b1;
          dst_wa = dst_addr;
          rsp_d.copy_width = wd_q;
          rsp_d.copy_height = hd_q;
          set_rsp = 1'b1;
          if (last_x && last_y) state_d = ST_DIVX;
        end else begin
          state_d = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (!xfer_ok || (stretch_q && req_q.key_enable)) begin
          state_d = ST_RESP;
        end else if (!stretch_q) begin
          src_re = 1'b1;
          state_d = ST_RDSRC;
        end else begin
          div_start = !div_done && (xr_q == '1);
          if (div_done) state_d = ST_DIVY;
        end
      end
      ST_DIVY: begin
        div_num = hs_q; div_den = hd_q;
        div_start = !div_done && (yr_q == '1);
        if (div_done) begin
          state_d = ST_RDSRC;
        end
      end
      ST_RDSRC: begin
        state_d = ST_WRDST;
      end
      ST_WRDST: begin
        dst_wa = dst_addr;
        dst_wd = cpix;
        dst_we = keep;
        if (!req_q.fill_enable) begin
          rsp_d.copy_width = xw_q;
          rsp_d.copy_height = yh_q;
          set_rsp = 1'b1;
        end
        state_d = (last_x && last_y) ? ST_RESP : ST_RDSRC;
      end
      ST_RDDST: begin
        rsp_d.read_data = pmask(dst_rd_q, pix16_q);
        set_rsp = 1'b1;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_RDSRC || (state_q == ST_DIVX && !stretch_q)) src_re = 1'b1;
  end

  // surface memories; read port registered
  logic [AW-1:0] src_ra;
  assign src_ra = (state_q == ST_DIVX) ? lin(sl_q, st_q, sw) : src_addr;
  always_ff @(posedge clk_i) begin
    if (src_we) src_mem[AddrW'(src_wa)] <= dst_wd;
    if (src_re) src_rd_q <= src_mem[AddrW'(src_ra)];
  end
  always_ff @(posedge clk_i) begin
    if (dst_we) dst_mem[AddrW'(dst_wa)] <= dst_wd;
    if (dst_re) dst_rd_q <= dst_mem[AddrW'(acc_addr)];
  end

  // walk counters and geometry
  always_ff @(posedge clk_i) begin
    if (in_fire) req_q <= in_i.data;
    if (state_q == ST_CLIP) begin
      sl_q <= c_sl; st_q <= c_st; dl_q <= c_dl; dt_q <= c_dt;
      ws_q <= c_sr - c_sl; hs_q <= c_sb - c_st;
      wd_q <= c_dr - c_dl; hd_q <= c_db - c_dt;
      xw_q <= c_dr - c_dl; yh_q <= c_db - c_dt;
      x_q <= '0; y_q <= '0;
      stretch_q <= (usw != udw) || (ush != udh);
      xr_q <= '1; yr_q <= '1;
    end
    if (state_q == ST_FILL) begin
      if (state_d == ST_DIVX) begin
        x_q <= '0; y_q <= '0;
        sx_acc_q <= '0; sy_acc_q <= '0;
        xw_q <= stretch_q ? wd_q : min9(ws_q, wd_q);
        yh_q <= stretch_q ? hd_q : min9(hs_q, hd_q);
      end else if (last_x) begin
        x_q <= '0; y_q <= y_q + 9'd1;
      end else begin
        x_q <= x_q + 9'd1;
      end
    end
    if (state_q == ST_DIVX && div_done) xr_q <= div_quot + 25'd1;
    if (state_q == ST_DIVY && div_done) yr_q <= div_quot + 25'd1;
    if (state_q == ST_WRDST) begin
      if (last_x) begin
        x_q <= '0; y_q <= y_q + 9'd1;
        sx_acc_q <= '0;
        sy_acc_q <= sy_acc_q + {9'd0, yr_q};
      end else begin
        x_q <= x_q + 9'd1;
        sx_acc_q <= sx_acc_q + {9'd0, xr_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_RESP) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_rsp) rsp_q <= rsp_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data = rsp_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_i.ready) else $error("input accepted while busy");
  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP) |=> out_o.valid) else $error("result missing");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !(src_we || dst_we)) else $error("write while idle");
`endif
endmodule
`default_nettype wire

// ----- tb/rbe_blit_scoreboard.sv -----
// scoreboard for the rect blit engine: predicts each response from the request stream
// depends on rbe_pkg and rbe_if; watches the config, request and response channels
module rbe_blit_scoreboard
  import rbe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rbe_if              cfg_mon,
  rbe_if              req_mon,
  rbe_if              rsp_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  localparam int unsigned SurfMax = 256;

  logic [PixW-1:0] src_pix [0:65535];
  logic [PixW-1:0] dst_pix [0:65535];
  logic [8:0]  src_w, src_h, dst_w, dst_h;
  logic        pix16;
  logic [15:0] key_lo, key_hi;
  rsp_t        rsp_q[$];

  assign pending_o = rsp_q.size();

  function automatic logic [15:0] pmask(input logic [15:0] v);
    return pix16 ? v : (v & Mask8);
  endfunction

  function automatic int unsigned clampd(input logic [8:0] v);
    return (v > SurfMax) ? SurfMax : int'(v);
  endfunction

  function automatic int unsigned umin(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  // applies one request to the surface copies and returns its response
  function automatic rsp_t apply_request(input req_t r);
    int unsigned sw, sh, dw, dh, sl, st, sr, sb, dl, dt, dr, db;
    int unsigned ws, hs, wd, hd, w, h, sx, sy;
    longint unsigned xr, yr;
    logic [15:0] c;
    logic stretch;
    rsp_t o;
    o = '0;
    sw = clampd(src_w); sh = clampd(src_h);
    dw = clampd(dst_w); dh = clampd(dst_h);
    case (action_e'(r.action))
      ACT_WR_SRC: begin
        if (r.pos_x < sw && r.pos_y < sh) src_pix[r.pos_y * sw + r.pos_x] = pmask(r.pixel);
      end
      ACT_WR_DST: begin
        if (r.pos_x < dw && r.pos_y < dh) dst_pix[r.pos_y * dw + r.pos_x] = pmask(r.pixel);
      end
      ACT_RD_DST: begin
        if (r.pos_x < dw && r.pos_y < dh) o.read_data = pmask(dst_pix[r.pos_y * dw + r.pos_x]);
      end
      default: begin
        // stretch is decided on the unclipped rectangles
        stretch = ((int'(r.src_right) - int'(r.src_left)) != (int'(r.dst_right) - int'(r.pos_x)))
               || ((int'(r.src_bottom) - int'(r.src_top)) != (int'(r.dst_bottom) - int'(r.pos_y)));
        o.stretched = stretch;
        sr = umin(r.src_right, sw);  sl = umin(r.src_left, sr);
        sb = umin(r.src_bottom, sh); st = umin(r.src_top, sb);
        dr = umin(r.dst_right, dw);  dl = umin(r.pos_x, dr);
        db = umin(r.dst_bottom, dh); dt = umin(r.pos_y, db);
        ws = sr - sl; hs = sb - st; wd = dr - dl; hd = db - dt;
        if (r.fill_enable && wd > 0 && hd > 0) begin
          for (int unsigned y = 0; y < hd; y++)
            for (int unsigned x = 0; x < wd; x++)
              dst_pix[(dt + y) * dw + dl + x] = pmask(r.pixel);
          o.copy_width = wd[8:0];
          o.copy_height = hd[8:0];
        end
        if (ws > 0 && hs > 0 && wd > 0 && hd > 0) begin
          if (!stretch) begin
            w = umin(ws, wd); h = umin(hs, hd);
            for (int unsigned y = 0; y < h; y++)
              for (int unsigned x = 0; x < w; x++) begin
                c = pmask(src_pix[(st + y) * sw + sl + x]);
                if (!r.key_enable || c < key_lo || c > key_hi)
                  dst_pix[(dt + y) * dw + dl + x] = c;
              end
            if (!r.fill_enable) begin
              o.copy_width = w[8:0];
              o.copy_height = h[8:0];
            end
          end else if (!r.key_enable) begin
            // 9.16 nearest-neighbour ratio, clamped to the last source column and row
            xr = ((longint'(ws) << 16) / wd) + 1;
            yr = ((longint'(hs) << 16) / hd) + 1;
            for (int unsigned y = 0; y < hd; y++) begin
              sy = int'((longint'(y) * yr) >> 16);
              if (sy > hs - 1) sy = hs - 1;
              for (int unsigned x = 0; x < wd; x++) begin
                sx = int'((longint'(x) * xr) >> 16);
                if (sx > ws - 1) sx = ws - 1;
                dst_pix[(dt + y) * dw + dl + x] = pmask(src_pix[(st + sy) * sw + sl + sx]);
              end
            end
            o.copy_width = wd[8:0];
            o.copy_height = hd[8:0];
          end
        end
      end
    endcase
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t got, want;
    cfg_t cw;
    if (!rst_ni) begin
      src_w <= 9'd256; src_h <= 9'd256; dst_w <= 9'd256; dst_h <= 9'd256;
      pix16 <= 1'b0; key_lo <= '0; key_hi <= '0;
      rsp_q.delete();
      fail_count_o <= 0;
      checked_o <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.data;
        if (rsp_q.size() == 0) begin
          $error("response with nothing outstanding: %h", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = rsp_q.pop_front();
          checked_o <= checked_o + 1;
          if (got != want) begin
            fail_count_o <= fail_count_o + 1;
            if (got.read_data != want.read_data)
              $error("read_data exp %h got %h", want.read_data, got.read_data);
            if (got.stretched != want.stretched)
              $error("stretched exp %0d got %0d", want.stretched, got.stretched);
            if (got.copy_width != want.copy_width)
              $error("copy_width exp %0d got %0d", want.copy_width, got.copy_width);
            if (got.copy_height != want.copy_height)
              $error("copy_height exp %0d got %0d", want.copy_height, got.copy_height);
          end
        end
      end
      if (req_mon.valid && req_mon.ready) rsp_q.push_back(apply_request(req_mon.data));
      if (cfg_mon.valid && cfg_mon.ready) begin
        cw = cfg_mon.data;
        case (reg_idx_e'(cw.index))
          REG_SRC_W:  src_w <= cw.data[8:0];
          REG_SRC_H:  src_h <= cw.data[8:0];
          REG_DST_W:  dst_w <= cw.data[8:0];
          REG_DST_H:  dst_h <= cw.data[8:0];
          REG_PIX16:  pix16 <= cw.data[0];
          REG_KEY_LO: key_lo <= cw.data;
          REG_KEY_HI: key_hi <= cw.data;
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- tb/tb_rect_blit_engine_top.sv -----
// top of the rect blit engine testbench: clock, reset, stimulus and verdict
// depends on rbe_pkg, rbe_if, rect_blit_engine_top and rbe_blit_scoreboard
module tb_rect_blit_engine_top;
  import rbe_pkg::*;

  localparam int unsigned CycleLimit = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned cycles = 0;
  int unsigned fail_count, pending, checked;
  int unsigned blits = 0;
  int unsigned surf_sw, surf_sh, surf_dw, surf_dh;
  bit calm = 1'b0;
  bit long_hold = 1'b0;

  rbe_if #(.T(cfg_t)) cfg_ch ();
  rbe_if #(.T(req_t)) req_ch ();
  rbe_if #(.T(rsp_t)) rsp_ch ();

  rect_blit_engine_top u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (req_ch),
    .out_o (rsp_ch)
  );

  rbe_blit_scoreboard u_scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_mon     (cfg_ch),
    .req_mon     (req_ch),
    .rsp_mon     (rsp_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
  end

  // response side: short random stalls, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_req(input req_t r);
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    if (r.action == ACT_BLIT) blits++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, data: val};
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  function automatic req_t mk_access(input action_e a, input int unsigned x,
                                     input int unsigned y, input logic [15:0] pix);
    req_t r;
    r = '0;
    r.action = a;
    r.pos_x = x[8:0];
    r.pos_y = y[8:0];
    r.pixel = pix;
    return r;
  endfunction

  function automatic req_t mk_blit(input int unsigned px, py, sl, st, sr, sb, dr, db,
                                   input bit fill, input bit key, input logic [15:0] pix);
    req_t r;
    r = mk_access(ACT_BLIT, px, py, pix);
    r.src_left = sl[8:0]; r.src_top = st[8:0];
    r.src_right = sr[8:0]; r.src_bottom = sb[8:0];
    r.dst_right = dr[8:0]; r.dst_bottom = db[8:0];
    r.fill_enable = fill;
    r.key_enable = key;
    return r;
  endfunction

  function automatic req_t rand_blit();
    int unsigned mode, sl, st, sr, sb, px, py;
    req_t r;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      r = mk_blit($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      sl = $urandom_range(0, surf_sw); st = $urandom_range(0, surf_sh);
      sr = $urandom_range(0, surf_sw + 1); sb = $urandom_range(0, surf_sh + 1);
      px = $urandom_range(0, surf_dw); py = $urandom_range(0, surf_dh);
      // half of the blits keep equal sizes so the plain and keyed copies get exercised
      if (mode < 6)
        r = mk_blit(px, py, sl, st, sr, sb, px + sr - sl, py + sb - st,
                    $urandom, $urandom, $urandom);
      else
        r = mk_blit(px, py, sl, st, sr, sb, $urandom_range(0, surf_dw + 1),
                    $urandom_range(0, surf_dh + 1), $urandom, $urandom, $urandom);
    end
    return r;
  endfunction

  function automatic req_t rand_access();
    action_e a;
    a = action_e'($urandom_range(0, 2));
    if ($urandom_range(0, 7) == 0) return mk_access(a, $urandom, $urandom, $urandom);
    if (a == ACT_WR_SRC)
      return mk_access(a, $urandom_range(0, surf_sw), $urandom_range(0, surf_sh), $urandom);
    return mk_access(a, $urandom_range(0, surf_dw), $urandom_range(0, surf_dh), $urandom);
  endfunction

  task automatic run_setup(input logic [8:0] sw, sh, dw, dh, input bit p16,
                           input logic [15:0] klo, khi, input int unsigned n_rand,
                           input bit directed);
    req_ch.valid <= 1'b0;
    // one edge so the last accepted transaction is counted as outstanding
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    write_reg(REG_SRC_W, 16'(sw));
    write_reg(REG_SRC_H, 16'(sh));
    write_reg(REG_DST_W, 16'(dw));
    write_reg(REG_DST_H, 16'(dh));
    write_reg(REG_PIX16, 16'(p16));
    write_reg(REG_KEY_LO, klo);
    write_reg(REG_KEY_HI, khi);
    cfg_ch.valid <= 1'b0;
    surf_sw = (sw > 256) ? 256 : sw; surf_sh = (sh > 256) ? 256 : sh;
    surf_dw = (dw > 256) ? 256 : dw; surf_dh = (dh > 256) ? 256 : dh;
    // fill both surfaces so no blit or read ever touches an unwritten pixel
    for (int unsigned y = 0; y < surf_sh; y++)
      for (int unsigned x = 0; x < surf_sw; x++)
        send_req(mk_access(ACT_WR_SRC, x, y, $urandom));
    for (int unsigned y = 0; y < surf_dh; y++)
      for (int unsigned x = 0; x < surf_dw; x++)
        send_req(mk_access(ACT_WR_DST, x, y, $urandom));
    if (directed) begin
      send_req(mk_access(ACT_WR_SRC, 0, 0, 16'hFFFF));
      send_req(mk_access(ACT_WR_DST, surf_dw - 1, surf_dh - 1, 16'h0000));
      send_req(mk_access(ACT_RD_DST, surf_dw - 1, surf_dh - 1, 16'h0));
      send_req(mk_access(ACT_RD_DST, surf_dw, 0, 16'h0));
      send_req(mk_access(ACT_WR_SRC, 511, 511, 16'h1234));
      send_req(mk_access(ACT_WR_DST, 256, 3, 16'h5678));
      send_req(mk_access(ACT_RD_DST, 0, 0, 16'h0));
      send_req(mk_access(ACT_RD_DST, 256, 256, 16'h0));
      send_req(mk_blit(2, 2, 0, 0, 4, 3, 6, 5, 0, 0, 16'h0));
      send_req(mk_blit(1, 1, 3, 2, 9, 7, 7, 6, 1, 1, 16'h00A5));
      send_req(mk_blit(0, 0, 0, 0, 3, 3, 14, 9, 0, 0, 16'h0));
      send_req(mk_blit(1, 1, 0, 0, 12, 10, 5, 4, 0, 0, 16'h0));
      send_req(mk_blit(0, 0, 0, 0, 3, 3, 14, 9, 1, 1, 16'hFF3C));
      send_req(mk_blit(0, 0, 8, 0, 2, 5, 6, 5, 1, 0, 16'h0011));
      send_req(mk_blit(0, 0, 0, 0, 256, 256, 256, 256, 0, 0, 16'h0));
      send_req(mk_blit(20, 0, 0, 0, 4, 4, 24, 4, 1, 0, 16'h0022));
      send_req(mk_blit(511, 511, 511, 511, 511, 511, 511, 511, 1, 1, 16'hFFFF));
      for (int unsigned y = 0; y < surf_dh; y++)
        send_req(mk_access(ACT_RD_DST, $urandom_range(0, surf_dw - 1), y, 16'h0));
    end
    for (int unsigned i = 0; i < n_rand; i++)
      send_req(($urandom_range(0, 1) == 0) ? rand_blit() : rand_access());
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_setup(9'd8, 9'd6, 9'd9, 9'd5, 1'b0, 16'h0020, 16'h0080, 30, 1'b1);
    // long receiver hold-off while the surface writes of the next setup run
    fork
      begin
        repeat (200) @(posedge clk_i);
        long_hold = 1'b1;
      end
    join_none
    run_setup(9'd5, 9'd4, 9'd6, 9'd4, 1'b1, 16'h1000, 16'h8000, 30, 1'b0);
    run_setup(9'd0, 9'd5, 9'd8, 9'd0, 1'b1, 16'h0000, 16'h0000, 20, 1'b0);
    run_setup(9'd4, 9'd4, 9'd4, 9'd4, 1'b0, 16'h00C0, 16'h0040, 30, 1'b0);
    calm = 1'b1;
    run_setup(9'd6, 9'd3, 9'd5, 9'd6, 1'b1, 16'h4000, 16'hC000, 40, 1'b0);
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("checked %0d responses, %0d of them blits, over five surface setups",
             checked, blits);
    $display("8/16-bit modes, clipped, keyed, stretched and empty rectangles exercised");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/rbe_pkg.sv
rtl/core/rbe_if.sv
rtl/core/rbe_div.sv
rtl/core/rect_blit_engine_top.sv
tb/rbe_blit_scoreboard.sv
tb/tb_rect_blit_engine_top.sv
